@@ rtl/core/alarm_indicator_qualifier_macros.svh @@
// Assertion helpers for the alarm indicator qualifier checker.
`ifndef ALARM_INDICATOR_QUALIFIER_MACROS_SVH
`define ALARM_INDICATOR_QUALIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AIQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("aiq check failed");

// Next-cycle implication, disabled during reset.
`define AIQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("aiq check failed");

`endif

@@ rtl/core/aiq_pkg.sv @@
`default_nettype none

package aiq_pkg;

    localparam int SCORE_MAX  = 8;
    localparam int SCORE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_DEF  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUN_CONFIRM    = 3'd0,
        REG_DEFECT_CONFIRM = 3'd1,
        REG_OFF_CONFIRM    = 3'd2,
        REG_STARTUP_LOCK   = 3'd3,
        REG_STARTUP_LOW    = 3'd4,
        REG_FILTER_HIGH    = 3'd5,
        REG_FILTER_LOW     = 3'd6,
        REG_HOLD_TICKS     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] high;
        logic [SCORE_W-1:0] low;
    } t_filt_thr;

    typedef struct packed {
        logic [7:0] run_confirm;
        logic [7:0] defect_confirm;
        logic [7:0] off_confirm;
        logic [9:0] startup_lock_ticks;
        logic [7:0] unlock_quiet_ticks;
        t_filt_thr  thr;
        logic [7:0] hold_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        run_confirm:        8'd60,
        defect_confirm:     8'd80,
        off_confirm:        8'd80,
        startup_lock_ticks: 10'd200,
        unlock_quiet_ticks: 8'd50,
        thr:                '{high: 4'd6, low: 4'd2},
        hold_ticks:         8'd40
    };

    typedef struct packed {
        logic  green_lamp;
        logic  red_lamp;
        logic  buzzer;
        t_mode active_mode;
        logic  unlocked;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/aiq_if.sv @@
`default_nettype none

interface aiq_in_if;
    logic valid;
    logic ready;
    logic raw_run;
    logic raw_defect;

    modport source (output valid, output raw_run, output raw_defect, input ready);
    modport sink (input valid, input raw_run, input raw_defect, output ready);
endinterface

interface aiq_out_if;
    logic       valid;
    logic       ready;
    logic       green_lamp;
    logic       red_lamp;
    logic       buzzer;
    logic [1:0] active_mode;
    logic       unlocked;

    modport source (output valid, output green_lamp, output red_lamp, output buzzer,
                    output active_mode, output unlocked, input ready);
    modport sink (input valid, input green_lamp, input red_lamp, input buzzer,
                  input active_mode, input unlocked, output ready);
endinterface

interface aiq_cfg_if import aiq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aiq_filter.sv @@
`default_nettype none

module aiq_filter import aiq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic      i_raw,
    input  wire t_filt_thr i_thr,
    output logic           o_level
);

    localparam logic [SCORE_W-1:0] SCORE_TOP = SCORE_W'(SCORE_MAX);

    logic [SCORE_W-1:0] r_score, n_score;
    logic               r_level, n_level;

    always_comb begin
        n_score = r_score;
        if (i_raw) begin
            if (r_score < SCORE_TOP) n_score = r_score + 1'b1;
        end else if (r_score != '0) begin
            n_score = r_score - 1'b1;
        end
        if (n_score >= i_thr.high) n_level = 1'b1;
        else if (n_score <= i_thr.low) n_level = 1'b0;
        else n_level = r_level;
    end

    assign o_level = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_score <= n_score;
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/aiq_ctrl.sv @@
`default_nettype none

module aiq_ctrl import aiq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_raw_run,
    input  wire logic i_raw_defect,
    input  wire logic i_lvl_run,
    input  wire logic i_lvl_def,
    input  wire t_cfg i_cfg,
    output logic      o_unlocked,
    output t_result   o_result
);

    t_mode      r_mode, n_mode;
    t_mode      r_pend, n_pend;
    logic [7:0] r_pcnt, n_pcnt;
    logic [9:0] r_elapsed, n_elapsed;
    logic [7:0] r_lrc, n_lrc;
    logic       r_ready, n_ready;
    logic [7:0] r_hold, n_hold;

    t_mode      code;
    logic [7:0] need;
    logic [7:0] pcnt_inc;
    logic [7:0] lrc_inc;
    logic       frozen;

    always_comb begin
        unique case ({i_lvl_run, i_lvl_def})
            2'b10:   code = MODE_RUN;
            2'b01:   code = MODE_DEF;
            2'b00:   code = MODE_OFF;
            default: code = MODE_NONE;
        endcase
    end

    always_comb begin
        unique case (code)
            MODE_DEF: need = i_cfg.defect_confirm;
            MODE_RUN: need = i_cfg.run_confirm;
            default:  need = i_cfg.off_confirm;
        endcase
    end

    assign pcnt_inc = (r_pcnt < need) ? r_pcnt + 8'd1 : r_pcnt;
    assign lrc_inc  = (r_lrc < i_cfg.unlock_quiet_ticks) ? r_lrc + 8'd1 : r_lrc;
    assign frozen   = (r_hold != 8'd0) && (r_hold != 8'd1);

    always_comb begin
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_pcnt    = r_pcnt;
        n_elapsed = r_elapsed;
        n_lrc     = r_lrc;
        n_ready   = r_ready;
        n_hold    = r_hold;
        if (!r_ready) begin
            n_mode = MODE_OFF;
            n_pend = MODE_NONE;
            n_pcnt = 8'd0;
            if (r_elapsed < i_cfg.startup_lock_ticks) begin
                n_elapsed = r_elapsed + 10'd1;
            end else if (!i_raw_run && !i_raw_defect) begin
                n_lrc = lrc_inc;
                if (lrc_inc >= i_cfg.unlock_quiet_ticks) n_ready = 1'b1;
            end else begin
                n_lrc = 8'd0;
            end
        end else begin
            if (r_hold != 8'd0) n_hold = r_hold - 8'd1;
            if (!frozen) begin
                if (code == MODE_NONE || code == r_mode) begin
                    n_pend = MODE_NONE;
                    n_pcnt = 8'd0;
                end else if (code != r_pend) begin
                    n_pend = code;
                    n_pcnt = 8'd1;
                end else if (pcnt_inc >= need) begin
                    n_mode = code;
                    n_hold = i_cfg.hold_ticks;
                    n_pend = MODE_NONE;
                    n_pcnt = 8'd0;
                end else begin
                    n_pcnt = pcnt_inc;
                end
            end
        end
    end

    assign o_unlocked           = r_ready;
    assign o_result.green_lamp  = (n_mode == MODE_RUN);
    assign o_result.red_lamp    = (n_mode == MODE_DEF);
    assign o_result.buzzer      = (n_mode == MODE_DEF);
    assign o_result.active_mode = n_mode;
    assign o_result.unlocked    = n_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_pend    <= MODE_NONE;
            r_pcnt    <= 8'd0;
            r_elapsed <= 10'd0;
            r_lrc     <= 8'd0;
            r_ready   <= 1'b0;
            r_hold    <= 8'd0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_pcnt    <= n_pcnt;
            r_elapsed <= n_elapsed;
            r_lrc     <= n_lrc;
            r_ready   <= n_ready;
            r_hold    <= n_hold;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/alarm_indicator_qualifier.sv @@
// Alarm indicator qualifier. Each input word is one scan tick with the raw
// running and defect lines; each accepted word yields exactly one result word
// (lamp, buzzer, applied mode and interlock state after that tick). One word
// is accepted per clock while the output buffer has room; the two filter lanes
// (once unlocked) and the confirmation counters update on acceptance. Results
// are registered into a two-entry output buffer, so the input stalls only
// when two results are waiting. Configuration writes are always ready and
// take effect on the next tick.
`default_nettype none

module alarm_indicator_qualifier import aiq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    aiq_in_if.sink    i_in,
    aiq_out_if.source o_out,
    aiq_cfg_if.sink   i_cfg
);

    t_cfg       r_cfg;
    logic       in_acc, out_acc;
    logic       unlocked, lvl_run, lvl_def;
    t_result    result;

    t_result    r_buf [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_RUN_CONFIRM:    r_cfg.run_confirm        <= i_cfg.data[7:0];
                REG_DEFECT_CONFIRM: r_cfg.defect_confirm     <= i_cfg.data[7:0];
                REG_OFF_CONFIRM:    r_cfg.off_confirm        <= i_cfg.data[7:0];
                REG_STARTUP_LOCK:   r_cfg.startup_lock_ticks <= i_cfg.data[9:0];
                REG_STARTUP_LOW:    r_cfg.unlock_quiet_ticks <= i_cfg.data[7:0];
                REG_FILTER_HIGH:    r_cfg.thr.high           <= i_cfg.data[SCORE_W-1:0];
                REG_FILTER_LOW:     r_cfg.thr.low            <= i_cfg.data[SCORE_W-1:0];
                REG_HOLD_TICKS:     r_cfg.hold_ticks         <= i_cfg.data[7:0];
                default:            ;
            endcase
        end
    end

    assign i_in.ready = (r_count != 2'd2);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    aiq_filter u_lane_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc && unlocked),
        .i_raw   (i_in.raw_run),
        .i_thr   (r_cfg.thr),
        .o_level (lvl_run)
    );

    aiq_filter u_lane_def (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc && unlocked),
        .i_raw   (i_in.raw_defect),
        .i_thr   (r_cfg.thr),
        .o_level (lvl_def)
    );

    aiq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_acc),
        .i_raw_run    (i_in.raw_run),
        .i_raw_defect (i_in.raw_defect),
        .i_lvl_run    (lvl_run),
        .i_lvl_def    (lvl_def),
        .i_cfg        (r_cfg),
        .o_unlocked   (unlocked),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) r_buf[r_wr_ptr] <= result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_acc) r_wr_ptr <= ~r_wr_ptr;
            if (out_acc) r_rd_ptr <= ~r_rd_ptr;
            case ({in_acc, out_acc})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_out.valid       = (r_count != 2'd0);
    assign o_out.green_lamp  = r_buf[r_rd_ptr].green_lamp;
    assign o_out.red_lamp    = r_buf[r_rd_ptr].red_lamp;
    assign o_out.buzzer      = r_buf[r_rd_ptr].buzzer;
    assign o_out.active_mode = r_buf[r_rd_ptr].active_mode;
    assign o_out.unlocked    = r_buf[r_rd_ptr].unlocked;

endmodule

`default_nettype wire

@@ rtl/core/aiq_checker.sv @@
`default_nettype none

`include "alarm_indicator_qualifier_macros.svh"

module aiq_checker import aiq_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_green,
    input wire logic       i_red,
    input wire logic       i_buzzer,
    input wire logic [1:0] i_mode,
    input wire logic       i_unlocked
);

    logic r_seen_unlock;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_unlock <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_unlocked) begin
            r_seen_unlock <= 1'b1;
        end
    end

    `AIQ_ASSERT_IMP(a_lamps_match_mode, i_clk, i_rst_n, i_out_valid, (i_green == (i_mode == MODE_RUN)) && (i_red == (i_mode == MODE_DEF)) && (i_buzzer == i_red))
    `AIQ_ASSERT_IMP(a_locked_is_off, i_clk, i_rst_n, i_out_valid && !i_unlocked, i_mode == MODE_OFF)
    `AIQ_ASSERT_IMP(a_unlock_sticks, i_clk, i_rst_n, i_out_valid && r_seen_unlock, i_unlocked)
    `AIQ_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mode) && $stable(i_unlocked))

endmodule

bind alarm_indicator_qualifier aiq_checker u_aiq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_green     (o_out.green_lamp),
    .i_red       (o_out.red_lamp),
    .i_buzzer    (o_out.buzzer),
    .i_mode      (o_out.active_mode),
    .i_unlocked  (o_out.unlocked)
);

`default_nettype wire

@@ sim/testbench.sv @@
module testbench;
    import aiq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        bit run;
        bit defect;
    } tick_word_t;

    logic i_clk;
    logic i_rst_n;

    aiq_in_if  in_if();
    aiq_out_if out_if();
    aiq_cfg_if cfg_if();

    alarm_indicator_qualifier u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    tick_word_t  tick_queue[$];
    t_result     relay_q[$];
    bit          in_taken;
    bit          idling_on;
    int unsigned in_gap;
    int unsigned out_stall;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned ticks_done;
    int unsigned results_seen;
    int unsigned switches;
    int unsigned settings_loaded;
    int unsigned unlock_tick;

    // predictor state
    t_cfg       shadow;
    logic [3:0] run_acc;
    logic [3:0] def_acc;
    bit         run_hi;
    bit         def_hi;
    t_mode      applied;
    t_mode      candidate;
    logic [7:0] cand_len;
    logic [7:0] quiet_run;
    logic [7:0] freeze_left;
    logic [9:0] lock_elapsed;
    bit         open_q;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string field, input logic [1:0] want,
                                 input logic [1:0] got);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at result %0d: %s expected %b got %b",
                     results_seen, field, want, got);
    endtask

    task automatic score_filter(input bit raw, inout logic [3:0] acc, inout bit hi);
        if (raw) begin
            if (acc < SCORE_MAX) acc = acc + 4'd1;
        end else if (acc != 4'd0) begin
            acc = acc - 4'd1;
        end
        if (acc >= shadow.thr.high) hi = 1'b1;
        else if (acc <= shadow.thr.low) hi = 1'b0;
    endtask

    function automatic logic [7:0] confirm_need(input t_mode m);
        case (m)
            MODE_DEF: return shadow.defect_confirm;
            MODE_RUN: return shadow.run_confirm;
            default:  return shadow.off_confirm;
        endcase
    endfunction

    task automatic qualify_tick(input bit rr, input bit rd, output t_result res);
        t_mode code;
        bit    frozen;
        frozen = 1'b0;
        if (!open_q) begin
            applied   = MODE_OFF;
            candidate = MODE_NONE;
            cand_len  = 8'd0;
            if (lock_elapsed < shadow.startup_lock_ticks) begin
                lock_elapsed = lock_elapsed + 10'd1;
            end else if (!rr && !rd) begin
                if (quiet_run < shadow.unlock_quiet_ticks) quiet_run = quiet_run + 8'd1;
                if (quiet_run >= shadow.unlock_quiet_ticks) begin
                    open_q      = 1'b1;
                    unlock_tick = ticks_done;
                end
            end else begin
                quiet_run = 8'd0;
            end
        end else begin
            score_filter(rr, run_acc, run_hi);
            score_filter(rd, def_acc, def_hi);
            case ({run_hi, def_hi})
                2'b10:   code = MODE_RUN;
                2'b01:   code = MODE_DEF;
                2'b00:   code = MODE_OFF;
                default: code = MODE_NONE;
            endcase
            if (freeze_left != 8'd0) begin
                freeze_left = freeze_left - 8'd1;
                frozen      = (freeze_left != 8'd0);
            end
            if (!frozen) begin
                if (code == MODE_NONE || code == applied) begin
                    candidate = MODE_NONE;
                    cand_len  = 8'd0;
                end else if (code != candidate) begin
                    candidate = code;
                    cand_len  = 8'd1;
                end else begin
                    if (cand_len < confirm_need(code)) cand_len = cand_len + 8'd1;
                    if (cand_len >= confirm_need(code)) begin
                        applied     = code;
                        freeze_left = shadow.hold_ticks;
                        candidate   = MODE_NONE;
                        cand_len    = 8'd0;
                        switches++;
                    end
                end
            end
        end
        res.green_lamp  = (applied == MODE_RUN);
        res.red_lamp    = (applied == MODE_DEF);
        res.buzzer      = (applied == MODE_DEF);
        res.active_mode = applied;
        res.unlocked    = open_q;
    endtask

    // input driver
    always @(negedge i_clk) begin
        tick_word_t next_word;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (in_gap != 0) begin
                in_if.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end else if (tick_queue.size() != 0) begin
                next_word = tick_queue.pop_front();
                in_if.valid      <= 1'b1;
                in_if.raw_run    <= next_word.run;
                in_if.raw_defect <= next_word.defect;
                if (idling_on && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 9);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (out_stall != 0) begin
            out_if.ready <= 1'b0;
            out_stall    <= out_stall - 1;
        end else begin
            out_if.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 6) == 0) out_stall <= $urandom_range(1, 9);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                in_taken = 1'b1;
                qualify_tick(in_if.raw_run, in_if.raw_defect, predicted);
                relay_q.push_back(predicted);
                ticks_done++;
            end
            if (out_if.valid && out_if.ready) begin
                if (relay_q.size() == 0) begin
                    flag_mismatch("word with none pending", 2'b00, 2'b00);
                end else begin
                    want = relay_q.pop_front();
                    if (out_if.green_lamp !== want.green_lamp)
                        flag_mismatch("green_lamp", 2'(want.green_lamp),
                                      2'(out_if.green_lamp));
                    if (out_if.red_lamp !== want.red_lamp)
                        flag_mismatch("red_lamp", 2'(want.red_lamp), 2'(out_if.red_lamp));
                    if (out_if.buzzer !== want.buzzer)
                        flag_mismatch("buzzer", 2'(want.buzzer), 2'(out_if.buzzer));
                    if (out_if.active_mode !== want.active_mode)
                        flag_mismatch("active_mode", want.active_mode, out_if.active_mode);
                    if (out_if.unlocked !== want.unlocked)
                        flag_mismatch("unlocked", 2'(want.unlocked), 2'(out_if.unlocked));
                end
                results_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("alarm_indicator_qualifier regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        logic [9:0] mask;
        logic [9:0] data;
        case (idx)
            REG_STARTUP_LOCK:               mask = 10'h3ff;
            REG_FILTER_HIGH, REG_FILTER_LOW: mask = 10'h00f;
            default:                        mask = 10'h0ff;
        endcase
        data = value[9:0] & mask;
        if ($urandom_range(0, 1) == 1) data = data | (10'($urandom) & ~mask);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_RUN_CONFIRM:    shadow.run_confirm        = data[7:0];
            REG_DEFECT_CONFIRM: shadow.defect_confirm     = data[7:0];
            REG_OFF_CONFIRM:    shadow.off_confirm        = data[7:0];
            REG_STARTUP_LOCK:   shadow.startup_lock_ticks = data[9:0];
            REG_STARTUP_LOW:    shadow.unlock_quiet_ticks = data[7:0];
            REG_FILTER_HIGH:    shadow.thr.high           = data[3:0];
            REG_FILTER_LOW:     shadow.thr.low            = data[3:0];
            default:            shadow.hold_ticks         = data[7:0];
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic load_settings(input int unsigned run_c, input int unsigned def_c,
                                 input int unsigned off_c, input int unsigned lock,
                                 input int unsigned low_n, input int unsigned hi,
                                 input int unsigned lo, input int unsigned hold);
        write_reg(REG_RUN_CONFIRM, run_c);
        write_reg(REG_DEFECT_CONFIRM, def_c);
        write_reg(REG_OFF_CONFIRM, off_c);
        write_reg(REG_STARTUP_LOCK, lock);
        write_reg(REG_STARTUP_LOW, low_n);
        write_reg(REG_FILTER_HIGH, hi);
        write_reg(REG_FILTER_LOW, lo);
        write_reg(REG_HOLD_TICKS, hold);
        settings_loaded++;
    endtask

    task automatic push_tick(input bit rr, input bit rd, input int unsigned reps);
        tick_word_t w;
        w.run    = rr;
        w.defect = rd;
        repeat (reps) tick_queue.push_back(w);
    endtask

    // runs of a steady line code with random noise flips
    task automatic queue_random(input int unsigned n);
        int unsigned len;
        int unsigned noise;
        bit          tr;
        bit          td;
        while (n > 0) begin
            case ($urandom_range(0, 9))
                0:       begin tr = 1'b1; td = 1'b1; end
                1, 2, 3: begin tr = 1'b0; td = 1'b0; end
                4, 5, 6: begin tr = 1'b1; td = 1'b0; end
                default: begin tr = 1'b0; td = 1'b1; end
            endcase
            len   = $urandom_range(1, 14);
            noise = ($urandom_range(0, 3) == 0) ? 50 : $urandom_range(0, 10);
            while (len > 0 && n > 0) begin
                push_tick(tr ^ ($urandom_range(0, 99) < noise),
                          td ^ ($urandom_range(0, 99) < noise), 1);
                len--;
                n--;
            end
        end
    endtask

    task automatic settle();
        while (tick_queue.size() != 0 || in_if.valid || relay_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned lock0;
        int unsigned low0;
        int unsigned hi;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.raw_run    = 1'b0;
        in_if.raw_defect = 1'b0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_RUN_CONFIRM;
        cfg_if.data      = '0;
        in_taken         = 1'b0;
        idling_on        = 1'b1;
        in_gap           = 0;
        out_stall        = 0;
        quiet_cycles     = 0;
        mismatches       = 0;
        ticks_done       = 0;
        results_seen     = 0;
        switches         = 0;
        settings_loaded  = 0;
        unlock_tick      = 0;
        shadow           = CFG_RESET;
        run_acc          = 4'd0;
        def_acc          = 4'd0;
        run_hi           = 1'b0;
        def_hi           = 1'b0;
        applied          = MODE_OFF;
        candidate        = MODE_NONE;
        cand_len         = 8'd0;
        quiet_run        = 8'd0;
        freeze_left      = 8'd0;
        lock_elapsed     = 10'd0;
        open_q           = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // start-up interlock: short lock, zero or small low-run requirement,
        // zero defect confirm, no hold
        lock0 = $urandom_range(0, 4);
        low0  = $urandom_range(0, 3);
        load_settings(1, 0, 2, lock0, low0, 3, 1, 0);
        repeat (lock0 + 1) push_tick($urandom_range(0, 1), $urandom_range(0, 1), 1);
        push_tick(1'b0, 1'b0, 1);
        push_tick(1'b1, 1'b0, 1);
        push_tick(1'b0, 1'b1, 1);
        push_tick(1'b1, 1'b1, 1);
        push_tick(1'b0, 1'b0, low0 + 1);
        push_tick(1'b1, 1'b0, 4);
        push_tick(1'b1, 1'b1, 3);
        push_tick(1'b0, 1'b1, 4);
        push_tick(1'b0, 1'b0, 4);
        queue_random(100);
        settle();

        // inverted hysteresis, one-tick hold
        load_settings(1, 1, 1, 1023, 255, 2, 5, 1);
        queue_random(120);
        settle();

        load_settings($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 8),
                      0, 1, 6, 2, $urandom_range(5, 12));
        queue_random(160);
        settle();

        // longest confirm and longest hold
        load_settings(255, 3, 2, 512, 128, 8, 0, 255);
        push_tick(1'b1, 1'b0, 270);
        push_tick(1'b0, 1'b1, 270);
        push_tick(1'b0, 1'b0, 20);
        settle();

        // line never reaches high
        load_settings(1, 1, 1, 7, 9, 15, 15, 2);
        queue_random(40);
        settle();

        // both lines always high
        load_settings(2, 2, 2, 300, 20, 0, 0, 3);
        queue_random(40);
        settle();

        idling_on = 1'b0;
        hi = $urandom_range(1, 8);
        load_settings($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                      $urandom_range(0, 1023), $urandom_range(1, 255), hi,
                      $urandom_range(0, hi - 1), $urandom_range(0, 10));
        queue_random(120);
        settle();

        $display("checked %0d tick words against %0d results over %0d settings",
                 ticks_done, results_seen, settings_loaded);
        $display("interlock opened at tick %0d; %0d relay mode switches predicted",
                 unlock_tick, switches);
        if (mismatches == 0) begin
            $display("alarm_indicator_qualifier regression: pass");
        end else begin
            $display("alarm_indicator_qualifier regression: fail");
        end
        $finish;
    end
endmodule
